// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, constants and helpers of the MIDI control change and system
// exclusive stream parser.
// ----------------------------------------------------------------------------
package msp_pkg;

  // Sizes
  localparam int unsigned PREAMBLE_MAX = 8;
  localparam int unsigned LEN_W        = 14;
  localparam int unsigned OUT_DATA_W   = 40;

  localparam logic [LEN_W-1:0] MAX_MESSAGE = 14'd8192;

  // MIDI byte codes
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [3:0] CC_STATUS_HI = 4'hB;
  localparam logic [7:0] STATUS_MIN   = 8'h80;

  // Result kinds on out_tuser
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_CC   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LISTEN_CHANNEL = 2'd0;
  localparam logic [1:0] REG_PREAMBLE_LEN   = 2'd1;
  localparam logic [1:0] REG_PREAMBLE_LO    = 2'd2;
  localparam logic [1:0] REG_PREAMBLE_HI    = 2'd3;

  // Parser mode
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_PENDING = 3'd1,
    MODE_ACQUIRE = 3'd2,
    MODE_IGNORE  = 3'd3,
    MODE_CC_NUM  = 3'd4,
    MODE_CC_VAL  = 3'd5
  } mode_t;

  // What a queued group of results holds
  typedef enum logic [2:0] {
    GRP_BURST    = 3'd0,
    GRP_DATA     = 3'd1,
    GRP_DATA_END = 3'd2,
    GRP_END      = 3'd3,
    GRP_CC       = 3'd4
  } grp_t;

  // Pick expected preamble byte i out of the two words
  function automatic logic [7:0] pre_byte(input logic [31:0] lo, input logic [31:0] hi,
                                          input logic [2:0] i);
    logic [31:0] w;
    begin
      w = i[2] ? hi : lo;
      pre_byte = w[{i[1:0], 3'b000} +: 8];
    end
  endfunction

endpackage

// ===== sv/midi_sysex_cc_stream_parser.sv =====
// ----------------------------------------------------------------------------
// midi_sysex_cc_stream_parser
// Parses a MIDI byte stream, reports control changes on one channel and
// system exclusive messages that open with a configured preamble.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | tvalid / tready    | tdata: in_byte[7:0]
//  out_    | master    | tvalid / tready    | tdata, tuser = kind, tlast = last
//  cfg_    | apb slave | psel/penable/ready | four registers at 0x0,0x4,0x8,0xC
//
//  One byte is parsed per cycle: an input register feeds the parse logic,
//  which loads a result group register that drains one result per cycle.
//  A group holds one or two results, or up to eight for a preamble burst;
//  the input side stalls only while a group is still draining.
//  Reset (rst_n low, synchronous) clears mode, count, held controller and
//  all configuration registers. Back pressure on out_tready holds the
//  current result and, once the input register is full, in_tready.
//
module midi_sysex_cc_stream_parser
  import msp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // [7:0] in_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // [6:0] data_byte, [20:7] message_length,
                                              // [24:21] cc_channel, [31:25] cc_number,
                                              // [38:32] cc_value, [39] zero
  output logic [1:0]            out_tuser,    // [1:0] kind
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers
  logic [3:0]  listen_ch_r;
  logic [3:0]  pre_len_r;
  logic [31:0] pre_lo_r;
  logic [31:0] pre_hi_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write a register at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_ch_r <= '0;
      pre_len_r   <= '0;
      pre_lo_r    <= '0;
      pre_hi_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LISTEN_CHANNEL: listen_ch_r <= cfg_pwdata[3:0];
        REG_PREAMBLE_LEN:   pre_len_r   <= cfg_pwdata[3:0];
        REG_PREAMBLE_LO:    pre_lo_r    <= cfg_pwdata;
        REG_PREAMBLE_HI:    pre_hi_r    <= cfg_pwdata;
        default:            pre_hi_r    <= pre_hi_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_LISTEN_CHANNEL: cfg_prdata = {28'd0, listen_ch_r};
      REG_PREAMBLE_LEN:   cfg_prdata = {28'd0, pre_len_r};
      REG_PREAMBLE_LO:    cfg_prdata = pre_lo_r;
      REG_PREAMBLE_HI:    cfg_prdata = pre_hi_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // Input register and group register state
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        grp_vld_r;
  grp_t        grp_sel_r;
  logic [3:0]  grp_cnt_r;
  logic [2:0]  grp_idx_r;
  logic [6:0]  grp_data_r;
  logic [LEN_W-1:0] grp_len_r;
  logic [3:0]  grp_ch_r;
  logic [6:0]  grp_num_r;
  logic [6:0]  grp_val_r;

  // Parser state
  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [6:0]       held_r, held_nxt;

  logic grp_last;
  logic grp_adv;
  logic grp_done;
  logic consume;

  assign grp_last  = ({1'b0, grp_idx_r} == (grp_cnt_r - 4'd1));
  assign grp_adv   = grp_vld_r && out_tready;
  assign grp_done  = grp_adv && grp_last;
  assign consume   = in_vld_r && (!grp_vld_r || grp_done);
  assign in_tready = !in_vld_r || consume;

  // Hold the accepted byte until the parse logic takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Parse logic
  logic [3:0]       plen;
  logic [7:0]       n;
  logic             is_status;
  logic             is_realtime;
  logic [LEN_W-1:0] count_inc;
  mode_t            idle_mode;
  logic             idle_start;
  grp_t             new_sel;
  logic [3:0]       new_cnt;
  logic [6:0]       new_data;
  logic [LEN_W-1:0] new_len;

  assign plen        = (pre_len_r > 4'(PREAMBLE_MAX)) ? 4'(PREAMBLE_MAX) : pre_len_r;
  assign n           = in_byte_r;
  assign is_status   = (n >= STATUS_MIN) && (n <= SYSEX_END);
  assign is_realtime = (n > SYSEX_END);
  assign count_inc   = count_r + 14'd1;

  // Decode a byte seen from idle
  always_comb begin
    idle_start = 1'b0;
    idle_mode  = MODE_IDLE;
    if (n == SYSEX_START) begin
      idle_start = 1'b1;
      idle_mode  = (plen != 4'd0) ? MODE_PENDING : MODE_ACQUIRE;
    end else if (n == {CC_STATUS_HI, listen_ch_r}) begin
      idle_mode = MODE_CC_NUM;
    end
  end

  // Next mode, count, held controller and the result group they cause
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    new_sel   = GRP_DATA;
    new_cnt   = 4'd0;
    new_data  = n[6:0];
    new_len   = count_r;
    case (mode_r)
      MODE_PENDING: begin
        if (is_status) begin
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end else if (!n[7]) begin
          if ((count_r >= 14'(plen)) ||
              (pre_byte(pre_lo_r, pre_hi_r, count_r[2:0]) != n)) begin
            mode_nxt = MODE_IGNORE;
          end else begin
            count_nxt = count_inc;
            if (count_inc >= 14'(plen)) begin
              mode_nxt = MODE_ACQUIRE;
              new_sel  = GRP_BURST;
              new_cnt  = count_inc[3:0];
            end
          end
        end
      end
      MODE_ACQUIRE: begin
        if (!n[7]) begin
          count_nxt = count_inc;
          new_sel   = GRP_DATA;
          new_cnt   = 4'd1;
          if (count_inc >= MAX_MESSAGE) begin
            new_sel   = GRP_DATA_END;
            new_cnt   = 4'd2;
            new_len   = count_inc;
            mode_nxt  = MODE_IDLE;
            count_nxt = '0;
          end
        end else if (is_status) begin
          new_sel   = GRP_END;
          new_cnt   = 4'd1;
          new_len   = count_r;
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
          if (n != SYSEX_END) begin
            mode_nxt = idle_mode;
          end
        end
      end
      MODE_IGNORE: begin
        if (is_status) begin
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end
      end
      MODE_CC_NUM, MODE_CC_VAL: begin
        if (is_status) begin
          mode_nxt  = idle_mode;
          count_nxt = '0;
        end else if (!n[7]) begin
          if (mode_r == MODE_CC_NUM) begin
            held_nxt = n[6:0];
            mode_nxt = MODE_CC_VAL;
          end else begin
            new_sel   = GRP_CC;
            new_cnt   = 4'd1;
            mode_nxt  = MODE_IDLE;
            count_nxt = '0;
          end
        end else if (is_realtime) begin
          mode_nxt = mode_r;
        end
      end
      default: begin
        mode_nxt = idle_mode;
        if (idle_start) begin
          count_nxt = '0;
        end
      end
    endcase
  end

  // Advance parser state on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
      held_r  <= '0;
    end else if (consume) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

  // Load a new group or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      grp_idx_r <= '0;
    end else if (consume) begin
      grp_vld_r <= (new_cnt != 4'd0);
      grp_idx_r <= '0;
    end else if (grp_adv) begin
      if (grp_last) begin
        grp_vld_r <= 1'b0;
      end else begin
        grp_idx_r <= grp_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      grp_sel_r  <= new_sel;
      grp_cnt_r  <= new_cnt;
      grp_data_r <= new_data;
      grp_len_r  <= new_len;
      grp_ch_r   <= listen_ch_r;
      grp_num_r  <= held_r;
      grp_val_r  <= n[6:0];
    end
  end

  // Form the current result from the group register
  logic [1:0]       o_kind;
  logic [6:0]       o_data;
  logic [LEN_W-1:0] o_len;
  logic [3:0]       o_ch;
  logic [6:0]       o_num;
  logic [6:0]       o_val;
  logic [7:0]       o_pre;

  assign o_pre = pre_byte(pre_lo_r, pre_hi_r, grp_idx_r);

  always_comb begin
    o_kind = KIND_DATA;
    o_data = '0;
    o_len  = '0;
    o_ch   = '0;
    o_num  = '0;
    o_val  = '0;
    case (grp_sel_r)
      GRP_BURST: o_data = o_pre[6:0];
      GRP_DATA:  o_data = grp_data_r;
      GRP_DATA_END: begin
        if (grp_idx_r == 3'd0) begin
          o_data = grp_data_r;
        end else begin
          o_kind = KIND_END;
          o_len  = grp_len_r;
        end
      end
      GRP_END: begin
        o_kind = KIND_END;
        o_len  = grp_len_r;
      end
      GRP_CC: begin
        o_kind = KIND_CC;
        o_ch   = grp_ch_r;
        o_num  = grp_num_r;
        o_val  = grp_val_r;
      end
      default: o_kind = KIND_DATA;
    endcase
  end

  assign out_tvalid = grp_vld_r;
  assign out_tuser  = o_kind;
  assign out_tlast  = grp_last;
  assign out_tdata  = {1'b0, o_val, o_num, o_ch, o_len, o_data};

  // Checks
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    grp_vld_r |-> ({1'b0, grp_idx_r} < grp_cnt_r))
    else $error("group index beyond group size");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_END)) |-> out_tlast)
    else $error("end result not marked last");

  a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PENDING) |-> (count_r < 14'(PREAMBLE_MAX)))
    else $error("preamble count out of range");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ACQUIRE) |-> (count_r < MAX_MESSAGE))
    else $error("message count reached cap while acquiring");

endmodule

// ===== tb/midi_sysex_cc_stream_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_sysex_cc_stream_parser_checker
// Watches the byte, result and register ports of the MIDI stream parser.
// Each accepted byte runs through a cycle-free model of the parser, and the
// results it causes are queued. Each result transaction is compared field by
// field with the oldest queued result. Register writes are snooped from the
// APB port so the model always uses the settings the block holds.
// ----------------------------------------------------------------------------
module midi_sysex_cc_stream_parser_checker
  import msp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output int                    fail_count,
  output int                    results_due,
  output int                    results_checked
);

  localparam int REPORT_MAX = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  data;
    logic [13:0] length;
    logic [3:0]  chan;
    logic [6:0]  num;
    logic [6:0]  val;
    logic        last;
  } midi_result_t;

  midi_result_t midi_results_due[$];

  // Parser model state and its copy of the registers
  mode_t       m_mode;
  logic [13:0] m_count;
  logic [6:0]  m_held;
  logic [3:0]  m_chan;
  logic [3:0]  m_plen;
  logic [63:0] m_preamble;   // {high word, low word}

  int errs;
  int seen;

  initial begin
    fail_count      = 0;
    results_due     = 0;
    results_checked = 0;
    errs            = 0;
    seen            = 0;
  end

  // Clamp the preamble length to what the parser can hold
  function automatic logic [3:0] match_length();
    return (m_plen > PREAMBLE_MAX) ? 4'(PREAMBLE_MAX) : m_plen;
  endfunction

  function automatic logic [7:0] preamble_at(input int idx);
    return m_preamble[8*idx +: 8];
  endfunction

  function automatic midi_result_t make_result(input logic [1:0] kind, input logic [6:0] data,
                                               input logic [13:0] length,
                                               input logic [3:0] chan, input logic [6:0] num,
                                               input logic [6:0] val);
    midi_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.length = length;
    r.chan   = chan;
    r.num    = num;
    r.val    = val;
    r.last   = 1'b0;
    return r;
  endfunction

  // Decode a byte as seen from the idle state
  task automatic start_from_idle(input logic [7:0] b);
    m_mode = MODE_IDLE;
    if (b == SYSEX_START) begin
      m_count = '0;
      m_mode  = (match_length() > 0) ? MODE_PENDING : MODE_ACQUIRE;
    end else if (b == {CC_STATUS_HI, m_chan}) begin
      m_mode = MODE_CC_NUM;
    end
  endtask

  task automatic back_to_idle();
    m_mode  = MODE_IDLE;
    m_count = '0;
  endtask

  // Advance the model by one byte and queue the results it causes
  task automatic parse_midi_byte(input logic [7:0] b);
    midi_result_t group_q[$];
    midi_result_t r;
    logic [3:0]   plen;
    plen = match_length();
    case (m_mode)
      MODE_PENDING: begin
        if (b >= STATUS_MIN && b <= SYSEX_END) begin
          back_to_idle();
        end else if (b < STATUS_MIN) begin
          if (m_count >= plen || preamble_at(m_count[2:0]) != b) begin
            m_mode = MODE_IGNORE;
          end else begin
            m_count++;
            if (m_count >= plen) begin
              m_mode = MODE_ACQUIRE;
              for (int i = 0; i < m_count && i < 8; i++)
                group_q.push_back(make_result(KIND_DATA, 7'(preamble_at(i)),
                                              '0, '0, '0, '0));
            end
          end
        end
      end
      MODE_ACQUIRE: begin
        if (b < STATUS_MIN) begin
          group_q.push_back(make_result(KIND_DATA, b[6:0], '0, '0, '0, '0));
          m_count++;
          if (m_count >= MAX_MESSAGE) begin
            group_q.push_back(make_result(KIND_END, '0, m_count, '0, '0, '0));
            back_to_idle();
          end
        end else if (b <= SYSEX_END) begin
          group_q.push_back(make_result(KIND_END, '0, m_count, '0, '0, '0));
          back_to_idle();
          if (b != SYSEX_END)
            start_from_idle(b);
        end
      end
      MODE_IGNORE: begin
        if (b >= STATUS_MIN && b <= SYSEX_END)
          back_to_idle();
      end
      MODE_CC_NUM: begin
        if (b < STATUS_MIN) begin
          m_held = b[6:0];
          m_mode = MODE_CC_VAL;
        end else if (b <= SYSEX_END) begin
          back_to_idle();
          start_from_idle(b);
        end
      end
      MODE_CC_VAL: begin
        if (b < STATUS_MIN) begin
          group_q.push_back(make_result(KIND_CC, '0, '0, m_chan, m_held, b[6:0]));
          back_to_idle();
        end else if (b <= SYSEX_END) begin
          back_to_idle();
          start_from_idle(b);
        end
      end
      default: start_from_idle(b);
    endcase
    // Mark the final result of this byte
    foreach (group_q[i]) begin
      r      = group_q[i];
      r.last = (i == group_q.size() - 1);
      midi_results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errs++;
      if (errs <= REPORT_MAX)
        $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Compare one result transaction with the oldest queued result
  task automatic compare_result();
    midi_result_t want;
    seen++;
    if (midi_results_due.size() == 0) begin
      errs++;
      if (errs <= REPORT_MAX)
        $display("%0t: unexpected result, expected none, actual kind 0x%0h tdata 0x%0h",
                 $time, out_tuser, out_tdata);
    end else begin
      want = midi_results_due.pop_front();
      check_field("kind",           want.kind,   out_tuser);
      check_field("data_byte",      want.data,   out_tdata[6:0]);
      check_field("message_length", want.length, out_tdata[20:7]);
      check_field("cc_channel",     want.chan,   out_tdata[24:21]);
      check_field("cc_number",      want.num,    out_tdata[31:25]);
      check_field("cc_value",       want.val,    out_tdata[38:32]);
      check_field("tdata pad bit",  0,           out_tdata[39]);
      check_field("last",           want.last,   out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      m_mode     = MODE_IDLE;
      m_count    = '0;
      m_held     = '0;
      m_chan     = '0;
      m_plen     = '0;
      m_preamble = '0;
      midi_results_due.delete();
    end else begin
      if (out_tvalid && out_tready)
        compare_result();
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_LISTEN_CHANNEL: m_chan            = cfg_pwdata[3:0];
          REG_PREAMBLE_LEN:   m_plen            = cfg_pwdata[3:0];
          REG_PREAMBLE_LO:    m_preamble[31:0]  = cfg_pwdata;
          REG_PREAMBLE_HI:    m_preamble[63:32] = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        parse_midi_byte(in_tdata);
    end
    fail_count      <= errs;
    results_due     <= midi_results_due.size();
    results_checked <= seen;
  end

endmodule

// ===== tb/midi_sysex_cc_stream_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_sysex_cc_stream_parser_tb
// Drives MIDI bytes and register writes into the stream parser and gives the
// verdict. A directed part walks control changes, preamble matching, drops,
// mismatches and mid-message register changes; random rounds follow under
// several settings, then a long output hold-off. Checking is done by the
// checker instance beside the block.
// ----------------------------------------------------------------------------
module midi_sysex_cc_stream_parser_tb;
  import msp_pkg::*;

  localparam int          LIMIT_CYCLES = 1000000;
  localparam int          SETTLE       = 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [7:0]  REALTIME_MIN = 8'hF8;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = 8'h00;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [3:0]            cfg_paddr   = 4'h0;
  logic [31:0]           cfg_pwdata  = 32'h0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int results_due;
  int results_checked;

  // Stimulus bookkeeping
  int          bytes_sent  = 0;
  int          cfg_writes  = 0;
  int          burst_left  = 0;
  int          cycle_count = 0;
  logic [3:0]  cur_chan    = 4'h0;
  logic [3:0]  cur_plen    = 4'h0;
  logic [63:0] cur_pre     = 64'h0;
  logic [7:0]  byte_script[$];

  // Receiver state
  int       hold_token = 0;
  int       hold_seen  = 0;
  int       hold_left  = 0;
  int       rx_left    = 0;
  int       rx_tick    = 0;
  rx_mode_t rx_style   = RX_OPEN;

  midi_sysex_cc_stream_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  midi_sysex_cc_stream_parser_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results still due", $time, results_due);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: change stall style now and then; hold off on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = rx_mode_t'($urandom_range(0, 3));
        rx_left  = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_style)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  // Offer one byte in bursts with random gaps; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic play_script();
    foreach (byte_script[i]) send_byte(byte_script[i]);
    byte_script.delete();
  endtask

  // Stop offering, wait for every due result, then let the pipeline settle
  task automatic quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup, access, then idle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_writes++;
    case (idx)
      REG_LISTEN_CHANNEL: cur_chan         = value[3:0];
      REG_PREAMBLE_LEN:   cur_plen         = value[3:0];
      REG_PREAMBLE_LO:    cur_pre[31:0]    = value;
      REG_PREAMBLE_HI:    cur_pre[63:32]   = value;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [3:0] chan, input logic [3:0] plen,
                         input logic [31:0] lo, input logic [31:0] hi);
    reg_write(REG_LISTEN_CHANNEL, {28'h0, chan});
    reg_write(REG_PREAMBLE_LEN, {28'h0, plen});
    reg_write(REG_PREAMBLE_LO, lo);
    reg_write(REG_PREAMBLE_HI, hi);
  endtask

  function automatic int active_plen();
    return (cur_plen > PREAMBLE_MAX) ? PREAMBLE_MAX : cur_plen;
  endfunction

  function automatic logic [7:0] realtime_byte();
    return REALTIME_MIN + 8'($urandom_range(0, 7));
  endfunction

  // Well-formed sysex with the current preamble and random payload
  task automatic send_sysex(input int ndata, input logic [7:0] term);
    send_byte(SYSEX_START);
    for (int i = 0; i < active_plen(); i++) send_byte(cur_pre[8*i +: 8]);
    for (int i = 0; i < ndata; i++) begin
      if ($urandom_range(0, 7) == 0) send_byte(realtime_byte());
      send_byte(8'($urandom_range(0, 127)));
    end
    send_byte(term);
  endtask

  task automatic send_cc(input logic [3:0] chan);
    send_byte({CC_STATUS_HI, chan});
    if ($urandom_range(0, 5) == 0) send_byte(realtime_byte());
    send_byte(8'($urandom_range(0, 127)));
    if ($urandom_range(0, 5) == 0) send_byte(realtime_byte());
    send_byte(8'($urandom_range(0, 127)));
  endtask

  // Sysex cut short by a status byte or broken by a wrong preamble byte
  task automatic send_broken_sysex();
    int k;
    k = $urandom_range(0, active_plen());
    send_byte(SYSEX_START);
    for (int i = 0; i < k; i++) send_byte(cur_pre[8*i +: 8]);
    if (active_plen() > 0 && $urandom_range(0, 1) == 1) begin
      send_byte((cur_pre[8*k[2:0] +: 8] ^ 8'($urandom_range(1, 127))) & 8'h7F);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 127)));
    end
    send_byte(8'($urandom_range(STATUS_MIN, SYSEX_END)));
  endtask

  task automatic random_round(input int nbytes);
    int first;
    int pick;
    logic [7:0] term;
    first = bytes_sent;
    while (bytes_sent - first < nbytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0, 1:    term = {CC_STATUS_HI, cur_chan};
          2:       term = SYSEX_START;
          default: term = SYSEX_END;
        endcase
        send_sysex($urandom_range(0, 6), term);
      end else if (pick < 65) begin
        send_cc(cur_chan);
      end else if (pick < 72) begin
        send_cc(cur_chan + 4'($urandom_range(1, 15)));
      end else if (pick < 82) begin
        send_broken_sysex();
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: channel 0, every sysex accepted
    byte_script = {8'hB0, 8'h00, 8'h00, 8'hB0, 8'h7F, 8'h7F,
                   8'hF0, 8'h00, 8'h7F, 8'hF7, 8'hF0, 8'hF7,
                   8'hB0, 8'hF8, 8'h01, 8'hFF, 8'h02,
                   8'hF0, 8'h22, 8'hB0, 8'h33, 8'h44};
    play_script();
    quiet();

    // Three byte preamble: match, mismatch, drop while pending, abandoned control change
    set_all(4'hF, 4'd3, 32'h0045_2301, 32'h7F7F_7F7F);
    byte_script = {8'hF0, 8'h01, 8'h23, 8'h45, 8'h7F, 8'hF7,
                   8'hF0, 8'h01, 8'h24, 8'h55, 8'h80,
                   8'hBF, 8'h0A, 8'hBF, 8'h0B, 8'h0C,
                   8'hF0, 8'h01, 8'h80, 8'h12,
                   8'hBF, 8'h30, 8'hF7};
    play_script();
    quiet();

    // Length above the maximum acts as eight: full burst
    set_all(4'hF, 4'hF, 32'h4433_2211, 32'h0877_6655);
    byte_script = {8'hF0, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h08,
                   8'h00, 8'hF7};
    play_script();
    quiet();

    // Shorten the preamble while a match is under way
    reg_write(REG_PREAMBLE_LEN, 32'd5);
    byte_script = {8'hF0, 8'h11, 8'h22, 8'h33};
    play_script();
    quiet();
    reg_write(REG_PREAMBLE_LEN, 32'd2);
    byte_script = {8'h44, 8'hF7, 8'hF0, 8'h11, 8'h22, 8'h3A, 8'hF7};
    play_script();
    quiet();

    // Change the channel between controller number and value
    reg_write(REG_LISTEN_CHANNEL, 32'd3);
    byte_script = {8'hB3, 8'h14};
    play_script();
    quiet();
    reg_write(REG_LISTEN_CHANNEL, 32'd9);
    byte_script = {8'h15};
    play_script();
    quiet();

    // Random rounds under several settings, extremes among them
    for (int round = 0; round < 6; round++) begin
      case (round)
        0: set_all(4'h0, 4'd0, $urandom & 32'h7F7F_7F7F, $urandom & 32'h7F7F_7F7F);
        1: set_all(4'hF, 4'd8, $urandom & 32'h7F7F_7F7F, $urandom & 32'h7F7F_7F7F);
        2: set_all(4'($urandom), 4'hF, $urandom, $urandom);
        3: set_all(4'($urandom), 4'($urandom_range(1, 7)),
                   $urandom & 32'h7F7F_7F7F, $urandom & 32'h7F7F_7F7F);
        4: set_all(4'($urandom), 4'd1, $urandom & 32'h7F7F_7F7F, $urandom);
        default: set_all(4'($urandom), 4'($urandom_range(0, 8)),
                         $urandom & 32'h7F7F_7F7F, $urandom & 32'h7F7F_7F7F);
      endcase
      random_round(3);
      quiet();
    end

    // Hold the result side off while full preamble bursts keep coming
    set_all(4'($urandom), 4'd8, $urandom & 32'h7F7F_7F7F, $urandom & 32'h7F7F_7F7F);
    hold_token++;
    repeat (2) send_sysex($urandom_range(2, 6), SYSEX_END);
    quiet();

    $display("Run: %0d bytes sent, %0d register writes, %0d results checked",
             bytes_sent, cfg_writes, results_checked);
    $display("Covered: control changes, preamble bursts and drops, long hold-off");
    if (fail_count == 0 && results_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/msp_pkg.sv
sv/midi_sysex_cc_stream_parser.sv
tb/midi_sysex_cc_stream_parser_checker.sv
tb/midi_sysex_cc_stream_parser_tb.sv
